FILE: design/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

   localparam int unsigned MAX_HEADER_BYTES_DEF = 4;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LENGTH_W   = 32;
   localparam int unsigned HDR_CNT_W  = 3;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_HEADER_BYTES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BIG_ENDIAN   = 1'd1;

   localparam logic [HDR_CNT_W-1:0] HEADER_BYTES_RST = 3'd4;
   localparam logic                 BIG_ENDIAN_RST   = 1'b1;

   typedef struct packed {
      logic [HDR_CNT_W-1:0] header_bytes;
      logic                 big_endian;
   } cfg_type;

   typedef struct packed {
      logic [LENGTH_W-1:0] body_length;
      logic                empty_body;
      logic                body_last;
      logic [BYTE_W-1:0]   body_byte;
   } result_type;

endpackage

FILE: design/length_prefix_deframer_unit.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_unit
// Splits a byte stream into length-prefixed frames and passes the bodies on.
//
// req_ carries one received byte per beat. Header beats (1 to 4 bytes, set by
// the header_bytes register, byte order by big_endian) are absorbed; each
// body byte leaves on rsp_ with tlast on the final one and the decoded body
// length alongside. A zero length header gives a single beat with tuser set
// and tlast set.
// The result of an accepted byte is registered into the output buffer before
// it shows on rsp_tvalid. One byte is taken every cycle while req_tready is
// high; the header/body state and length counters are registered, and a
// two-entry output buffer lets the block take a new byte while a result waits
// on a stalled receiver. req_tready falls only once both output entries are full.
// csr_ is always ready; register 0 is header_bytes, register 1 is big_endian.
// Reset returns to the header phase with header_bytes 4 and big_endian 1 and
// empties the output buffer.
// ----------------------------------------------------------------------------
module length_prefix_deframer_unit #(
   parameter int unsigned MAX_HEADER_BYTES = lpd_pkg::MAX_HEADER_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] in_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,   // [7:0] body_byte, [39:8] body_length
   output logic                            rsp_tlast,   // body_last
   output logic                            rsp_tuser,   // empty_body
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lpd_pkg::CSR_DATA_W-1:0]  csr_data
);

   lpd_pkg::cfg_type     cfg_ff, cfg_in;
   lpd_pkg::result_type  core_res;
   logic                 core_res_valid;
   logic                 accept;

   logic                 out_valid_ff, out_valid_in;
   lpd_pkg::result_type  out_ff, out_in;
   logic                 skid_valid_ff, skid_valid_in;
   lpd_pkg::result_type  skid_ff, skid_in;
   logic                 pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lpd_pkg::REG_HEADER_BYTES: cfg_in.header_bytes = csr_data;
            lpd_pkg::REG_BIG_ENDIAN:   cfg_in.big_endian   = csr_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_bytes <= lpd_pkg::HEADER_BYTES_RST;
         cfg_ff.big_endian   <= lpd_pkg::BIG_ENDIAN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   lpd_core #(
      .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_tdata),
      .cfg       (cfg_ff),
      .res_valid (core_res_valid),
      .res       (core_res)
   );

   // two-entry output buffer
   assign pop = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = core_res_valid;
            skid_in       = core_res;
         end else begin
            out_valid_in = core_res_valid;
            out_in       = core_res;
         end
      end else if (core_res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = core_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.body_length, out_ff.body_byte};
   assign rsp_tlast  = out_ff.body_last;
   assign rsp_tuser  = out_ff.empty_body;

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output entry empty");

   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !pop) |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid entry lost while receiver stalled");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> out_valid_ff && $stable(out_ff))
      else $error("output beat changed under stall");

endmodule

FILE: design/lpd_core.sv
// ----------------------------------------------------------------------------
// lpd_core
// Header and body phase tracking: assembles the length prefix and forms one
// result per body byte or per zero-length header.
// ----------------------------------------------------------------------------
module lpd_core #(
   parameter int unsigned MAX_HEADER_BYTES = lpd_pkg::MAX_HEADER_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [lpd_pkg::BYTE_W-1:0]    in_byte,
   input  lpd_pkg::cfg_type              cfg,
   output logic                          res_valid,
   output lpd_pkg::result_type           res
);

   localparam int unsigned CNT_W = lpd_pkg::HDR_CNT_W;
   localparam logic [CNT_W:0] MAX_HDR = (CNT_W+1)'(MAX_HEADER_BYTES);

   logic                            in_body_phase_ff, in_body_phase_in;
   logic [CNT_W-1:0]                header_index_ff, header_index_in;
   logic [lpd_pkg::LENGTH_W-1:0]    length_accum_ff, length_accum_in;
   logic [lpd_pkg::LENGTH_W-1:0]    bytes_left_ff, bytes_left_in;

   logic [CNT_W:0]                  hdr_count;
   logic [CNT_W-1:0]                index_inc;
   logic                            hdr_done;
   logic                            body_end;
   logic [lpd_pkg::LENGTH_W-1:0]    accum_next;
   logic [lpd_pkg::LENGTH_W-1:0]    byte_wide;

   always_comb begin
      hdr_count = {1'b0, cfg.header_bytes};
      if (hdr_count == '0) begin
         hdr_count = (CNT_W+1)'(1);
      end else if (hdr_count > MAX_HDR) begin
         hdr_count = MAX_HDR;
      end
   end

   assign byte_wide = lpd_pkg::LENGTH_W'(in_byte);

   always_comb begin
      accum_next = length_accum_ff;
      if (cfg.big_endian) begin
         accum_next = {length_accum_ff[lpd_pkg::LENGTH_W-lpd_pkg::BYTE_W-1:0], in_byte};
      end else if (!header_index_ff[CNT_W-1]) begin
         case (header_index_ff[1:0])
            2'd0:    accum_next = length_accum_ff | byte_wide;
            2'd1:    accum_next = length_accum_ff | (byte_wide << 8);
            2'd2:    accum_next = length_accum_ff | (byte_wide << 16);
            default: accum_next = length_accum_ff | (byte_wide << 24);
         endcase
      end
   end

   assign index_inc = header_index_ff + CNT_W'(1);
   assign hdr_done  = (index_inc == '0) || ({1'b0, index_inc} >= hdr_count);
   assign body_end  = (bytes_left_ff <= lpd_pkg::LENGTH_W'(1));

   always_comb begin
      in_body_phase_in = in_body_phase_ff;
      header_index_in  = header_index_ff;
      length_accum_in  = length_accum_ff;
      bytes_left_in    = bytes_left_ff;
      res_valid        = 1'b0;
      res              = '0;
      if (accept) begin
         if (!in_body_phase_ff) begin
            length_accum_in = accum_next;
            header_index_in = index_inc;
            if (hdr_done) begin
               header_index_in = '0;
               if (accum_next == '0) begin
                  res_valid      = 1'b1;
                  res.body_last  = 1'b1;
                  res.empty_body = 1'b1;
               end else begin
                  bytes_left_in    = accum_next;
                  in_body_phase_in = 1'b1;
               end
            end
         end else begin
            res_valid       = 1'b1;
            res.body_byte   = in_byte;
            res.body_last   = body_end;
            res.body_length = length_accum_ff;
            if (body_end) begin
               bytes_left_in    = '0;
               in_body_phase_in = 1'b0;
               header_index_in  = '0;
               length_accum_in  = '0;
            end else begin
               bytes_left_in = bytes_left_ff - lpd_pkg::LENGTH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_phase_ff <= 1'b0;
         header_index_ff  <= '0;
         length_accum_ff  <= '0;
         bytes_left_ff    <= '0;
      end else begin
         in_body_phase_ff <= in_body_phase_in;
         header_index_ff  <= header_index_in;
         length_accum_ff  <= length_accum_in;
         bytes_left_ff    <= bytes_left_in;
      end
   end

   // body phase always has bytes to come
   assert property (@(posedge clock) disable iff (reset)
      in_body_phase_ff |-> (bytes_left_ff != '0) && (length_accum_ff != '0))
      else $error("body phase with nothing left");

   assert property (@(posedge clock) disable iff (reset)
      !in_body_phase_ff |-> (bytes_left_ff == '0))
      else $error("bytes left outside body phase");

   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.empty_body) |->
         (res.body_last && (res.body_length == '0) && !in_body_phase_ff))
      else $error("malformed empty-body marker");

endmodule
